>>> rtl/mtsq_pkg.sv
// ============================================================================
// mtsq_pkg
// Shared codes, types and helpers of the MIDI track step quantizer.
// ============================================================================
package mtsq_pkg;

    localparam int STEPS_MAX_DEF = 32;
    localparam int CH_COUNT      = 16;
    localparam int DRUM_TRACKS   = 4;

    localparam logic [23:0] TEMPO_DEFAULT = 24'd500000;
    localparam logic [14:0] TPQ_RST       = 15'd480;
    localparam logic [1:0]  BARS_RST      = 2'd2;
    localparam logic [3:0]  DRUM_CH_RST   = 4'd9;

    // register indexes
    localparam logic [1:0] REG_TPQ  = 2'd0;
    localparam logic [1:0] REG_BARS = 2'd1;
    localparam logic [1:0] REG_DRUM = 2'd2;

    // item functions
    localparam logic [1:0] F_TRACK = 2'd0;
    localparam logic [1:0] F_READ  = 2'd1;
    localparam logic [1:0] F_CLEAR = 2'd2;

    // parse phases
    localparam logic [3:0] PH_DELTA      = 4'd0;
    localparam logic [3:0] PH_STATUS     = 4'd1;
    localparam logic [3:0] PH_META_TYPE  = 4'd2;
    localparam logic [3:0] PH_META_LEN   = 4'd3;
    localparam logic [3:0] PH_TEMPO_DATA = 4'd4;
    localparam logic [3:0] PH_SYSEX_LEN  = 4'd5;
    localparam logic [3:0] PH_SKIP       = 4'd6;
    localparam logic [3:0] PH_DATA1      = 4'd7;
    localparam logic [3:0] PH_DATA2      = 4'd8;

    // result kinds
    localparam logic [2:0] K_NONE    = 3'd0;
    localparam logic [2:0] K_MELODIC = 3'd1;
    localparam logic [2:0] K_DRUM    = 3'd2;
    localparam logic [2:0] K_OUTSIDE = 3'd3;
    localparam logic [2:0] K_READ    = 3'd4;
    localparam logic [2:0] K_BADLEN  = 3'd5;
    localparam logic [2:0] K_NORUN   = 3'd6;

    localparam logic [7:0] B_META  = 8'hFF;
    localparam logic [7:0] B_SYSEX = 8'hF0;
    localparam logic [7:0] B_ESC   = 8'hF7;
    localparam logic [7:0] M_TEMPO = 8'h51;

    typedef struct packed {
        logic capture;
        logic exec;
        logic div_step;
        logic place;
        logic mel_wr;
        logic rd_take;
        logic push;
        logic clr_step;
    } t_cmd;

    typedef struct packed {
        logic go_div;
        logic is_read;
        logic is_clear;
        logic div_last;
        logic mel;
        logic clr_last;
        logic out_free;
    } t_stat;

    function automatic logic [1:0] drum_track(input logic [6:0] n);
        logic [1:0] t;
        t = 2'd3;
        if (n == 7'd35 || n == 7'd36) t = 2'd0;
        else if (n == 7'd37 || n == 7'd38 || n == 7'd40) t = 2'd1;
        else if (n == 7'd42 || n == 7'd44 || n == 7'd46) t = 2'd2;
        return t;
    endfunction

endpackage

>>> rtl/mtsq_ctrl.sv
// ============================================================================
// mtsq_ctrl
// Sequencer: steps each item through execute, divide and place (note-ons in the window)
// or read (cell reads), and output; also runs the grid clear sweep.
module mtsq_ctrl
    import mtsq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_ready
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_PLACE = 3'd4;
    localparam logic [2:0] S_MWR   = 3'd5;
    localparam logic [2:0] S_RDATA = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_clr_after, n_clr_after;

    always_comb begin
        o_cmd       = '0;
        o_ready     = 1'b0;
        n_state     = r_state;
        n_clr_after = r_clr_after;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_accept) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec  = 1'b1;
                n_clr_after = i_stat.is_clear;
                priority if (i_stat.go_div) n_state = S_DIV;
                else if (i_stat.is_read)    n_state = S_RDATA;
                else                        n_state = S_FIN;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_PLACE;
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = i_stat.mel ? S_MWR : S_FIN;
            end
            S_MWR: begin
                o_cmd.mel_wr = 1'b1;
                n_state      = S_FIN;
            end
            S_RDATA: begin
                o_cmd.rd_take = 1'b1;
                n_state       = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.push  = 1'b1;
                    n_state     = r_clr_after ? S_CLEAR : S_IDLE;
                    n_clr_after = 1'b0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_after <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_after <= n_clr_after;
        end
    end

endmodule

>>> rtl/mtsq_dp.sv
// ============================================================================
// mtsq_dp
// Datapath: byte parser, step divider, note grids and output register.
// ============================================================================
module mtsq_dp
    import mtsq_pkg::*;
#(
    parameter int STEPS_MAX = STEPS_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_byte,
    input  logic        i_ts,
    input  logic        i_te,
    input  logic [4:0]  i_rrow,
    input  logic [4:0]  i_rstep,
    input  logic [14:0] i_tpq,
    input  logic [1:0]  i_bars,
    input  logic [3:0]  i_drum_ch,
    input  logic        i_m_ready,
    output logic        o_m_valid,
    output logic [87:0] o_m_data
);

    localparam int SW        = $clog2(STEPS_MAX);
    localparam int MEL_DEPTH = CH_COUNT << SW;
    localparam int DRM_DEPTH = DRUM_TRACKS << SW;
    localparam int MAW       = $clog2(MEL_DEPTH);
    localparam int DAW       = $clog2(DRM_DEPTH);

    // captured item
    logic [1:0] r_func;
    logic [7:0] r_byte;
    logic       r_ts, r_te;
    logic [4:0] r_rrow, r_rstep;

    // parser and statistics
    logic [3:0]  r_phase, n_phase;
    logic [7:0]  r_run, n_run;
    logic [7:0]  r_evst, n_evst;
    logic [31:0] r_tick, n_tick;
    logic [27:0] r_lval, n_lval;
    logic [2:0]  r_lbytes, n_lbytes;
    logic [27:0] r_skip, n_skip;
    logic [7:0]  r_meta, n_meta;
    logic [23:0] r_tempo, n_tempo;
    logic [6:0]  r_fdata, n_fdata;
    logic [15:0] r_chseen, n_chseen;
    logic        r_drum, n_drum;
    logic [15:0] r_notes, n_notes;
    logic        r_err, n_err;

    // note placement and result
    logic [3:0]  r_ch, n_ch;
    logic [20:0] r_rem, n_rem;
    logic [5:0]  r_quo, n_quo;
    logic [2:0]  r_dcnt, n_dcnt;
    logic [2:0]  r_kind, n_kind;
    logic [4:0]  r_row, n_row;
    logic [4:0]  r_step, n_step;
    logic [6:0]  r_note, n_note;
    logic [7:0]  r_cell, n_cell;

    logic [MAW-1:0] r_clr_addr;
    logic           r_m_valid;
    logic [87:0]    r_m_data;

    logic [7:0] mem_mel [MEL_DEPTH];
    logic       mem_drm [DRM_DEPTH];
    logic [7:0] r_mel_rd;
    logic       r_drm_rd;

    // item view after track start
    logic [31:0] tk_in;
    logic [27:0] lv_in;
    logic [2:0]  lb_in;
    logic [7:0]  rs_in;
    logic [3:0]  ph_in;
    logic [27:0] f_val;
    logic [2:0]  f_cnt;
    logic        f_done, f_bad;
    logic [32:0] tick_sum;
    logic [17:0] span;
    logic [7:0]  td_ev;
    logic        td_short;
    logic [5:0]  bars16;
    logic        pl_out, pl_drum, mel_upd;
    logic [1:0]  pl_trk;
    logic [21:0] d_sh;
    logic        d_ge;
    logic [MAW-1:0] pl_addr, rd_addr, mel_addr;
    logic [DAW-1:0] drm_pl_addr, drm_rd_addr;
    logic        rd_ok;

    assign tk_in    = r_ts ? 32'd0 : r_tick;
    assign lv_in    = r_ts ? 28'd0 : r_lval;
    assign lb_in    = r_ts ? 3'd0 : r_lbytes;
    assign rs_in    = r_ts ? 8'd0 : r_run;
    assign ph_in    = r_ts ? PH_DELTA : r_phase;
    assign f_val    = {lv_in[20:0], r_byte[6:0]};
    assign f_cnt    = lb_in + 3'd1;
    assign f_done   = !r_byte[7];
    assign f_bad    = r_byte[7] && (f_cnt >= 3'd4);
    assign tick_sum = {1'b0, tk_in} + {5'd0, f_val};
    assign span     = (i_bars == 2'd1) ? {1'b0, i_tpq, 2'b00} : {i_tpq, 3'b000};
    assign td_ev    = (ph_in == PH_DATA1) ? r_evst : rs_in;
    assign td_short = (td_ev[7:4] == 4'hC) || (td_ev[7:4] == 4'hD);

    assign bars16  = (i_bars == 2'd1) ? 6'd16 : 6'd32;
    assign pl_out  = (r_quo >= bars16) || (32'(r_quo) >= 32'(STEPS_MAX));
    assign pl_drum = (r_ch == i_drum_ch);
    assign pl_trk  = drum_track(r_note);
    assign mel_upd = ({1'b0, r_note} + 8'd1) > r_mel_rd;

    assign d_sh = 22'(i_tpq) << r_dcnt;
    assign d_ge = {1'b0, r_rem} >= d_sh;

    assign pl_addr     = {r_ch, r_quo[SW-1:0]};
    assign rd_addr     = {r_rrow[3:0], SW'(r_rstep)};
    assign mel_addr    = i_cmd.place ? pl_addr : rd_addr;
    assign drm_pl_addr = {pl_trk, r_quo[SW-1:0]};
    assign drm_rd_addr = {r_rrow[1:0], SW'(r_rstep)};
    assign rd_ok       = 32'(r_rstep) < 32'(STEPS_MAX);

    always_comb begin
        n_phase = r_phase;  n_run = r_run;      n_evst = r_evst;   n_tick = r_tick;
        n_lval = r_lval;    n_lbytes = r_lbytes; n_skip = r_skip;   n_meta = r_meta;
        n_tempo = r_tempo;  n_fdata = r_fdata;  n_chseen = r_chseen; n_drum = r_drum;
        n_notes = r_notes;  n_err = r_err;      n_ch = r_ch;       n_rem = r_rem;
        n_quo = r_quo;      n_dcnt = r_dcnt;    n_kind = r_kind;   n_row = r_row;
        n_step = r_step;    n_note = r_note;    n_cell = r_cell;
        o_stat          = '0;
        o_stat.is_read  = (r_func == F_READ);
        o_stat.is_clear = (r_func == F_CLEAR);
        o_stat.div_last = (r_dcnt == 3'd0);
        o_stat.clr_last = (r_clr_addr == MAW'(MEL_DEPTH - 1));
        o_stat.out_free = !r_m_valid || i_m_ready;

        if (i_cmd.exec) begin
            n_kind = K_NONE;
            n_row  = '0;
            n_step = '0;
            n_note = '0;
            n_cell = '0;
            unique case (r_func)
                F_TRACK: begin
                    if (!r_err) begin
                        n_tick = tk_in; n_run = rs_in; n_phase = ph_in;
                        n_lval = lv_in; n_lbytes = lb_in;
                        unique case (ph_in)
                            PH_DELTA: begin
                                n_lval   = f_val;
                                n_lbytes = f_cnt;
                                if (f_bad) begin
                                    n_err  = 1'b1;
                                    n_kind = K_BADLEN;
                                end else if (f_done) begin
                                    n_tick  = tick_sum[32] ? '1 : tick_sum[31:0];
                                    n_phase = PH_STATUS;
                                end
                            end
                            PH_STATUS: begin
                                priority if (r_byte == B_META) begin
                                    n_phase = PH_META_TYPE;
                                end else if (r_byte == B_SYSEX || r_byte == B_ESC) begin
                                    n_lval = '0; n_lbytes = '0; n_phase = PH_SYSEX_LEN;
                                end else if (r_byte >= B_SYSEX) begin
                                    n_lval = '0; n_lbytes = '0; n_phase = PH_DELTA;
                                end else if (r_byte[7]) begin
                                    n_run = r_byte; n_evst = r_byte; n_phase = PH_DATA1;
                                end else if (rs_in == 8'd0) begin
                                    n_err  = 1'b1;
                                    n_kind = K_NORUN;
                                end else begin
                                    n_evst = rs_in;
                                    if (td_short) begin
                                        n_lval = '0; n_lbytes = '0; n_phase = PH_DELTA;
                                    end else begin
                                        n_fdata = r_byte[6:0]; n_phase = PH_DATA2;
                                    end
                                end
                            end
                            PH_META_TYPE: begin
                                n_meta = r_byte; n_lval = '0; n_lbytes = '0;
                                n_phase = PH_META_LEN;
                            end
                            PH_META_LEN, PH_SYSEX_LEN: begin
                                n_lval   = f_val;
                                n_lbytes = f_cnt;
                                if (f_bad) begin
                                    n_err  = 1'b1;
                                    n_kind = K_BADLEN;
                                end else if (f_done) begin
                                    n_skip = f_val;
                                    priority if (f_val == 28'd0) n_phase = PH_DELTA;
                                    else if (ph_in == PH_META_LEN && r_meta == M_TEMPO
                                             && f_val == 28'd3) n_phase = PH_TEMPO_DATA;
                                    else n_phase = PH_SKIP;
                                    n_lval = '0; n_lbytes = '0;
                                end
                            end
                            PH_TEMPO_DATA: begin
                                n_lval = {4'd0, lv_in[15:0], r_byte};
                                n_skip = r_skip - 28'd1;
                                if (r_skip == 28'd1) begin
                                    n_tempo = {lv_in[15:0], r_byte};
                                    n_lval = '0; n_lbytes = '0; n_phase = PH_DELTA;
                                end
                            end
                            PH_SKIP: begin
                                if (r_skip > 28'd1) begin
                                    n_skip = r_skip - 28'd1;
                                end else begin
                                    n_skip = '0; n_lval = '0; n_lbytes = '0;
                                    n_phase = PH_DELTA;
                                end
                            end
                            PH_DATA1: begin
                                if (td_short) begin
                                    n_lval = '0; n_lbytes = '0; n_phase = PH_DELTA;
                                end else begin
                                    n_fdata = r_byte[6:0]; n_phase = PH_DATA2;
                                end
                            end
                            PH_DATA2: begin
                                if (r_evst[7:4] == 4'h9 && r_byte != 8'd0) begin
                                    n_note = r_fdata;
                                    if (r_notes != 16'hFFFF) n_notes = r_notes + 16'd1;
                                    if (i_tpq == 15'd0 || tk_in >= 32'(span)) begin
                                        n_kind = K_OUTSIDE;
                                    end else begin
                                        o_stat.go_div = 1'b1;
                                        n_rem  = 21'({tk_in[17:0], 2'b00}) + 21'(i_tpq[14:1]);
                                        n_quo  = '0;
                                        n_dcnt = 3'd5;
                                        n_ch   = r_evst[3:0];
                                    end
                                end
                                n_lval = '0; n_lbytes = '0; n_phase = PH_DELTA;
                            end
                            default: begin
                                n_lval = '0; n_lbytes = '0; n_phase = PH_DELTA;
                            end
                        endcase
                        // drop an unfinished event at end of track
                        if (r_te && !n_err) begin
                            n_phase = PH_DELTA; n_lval = '0; n_lbytes = '0; n_skip = '0;
                        end
                    end
                end
                F_READ: n_kind = K_READ;
                F_CLEAR: begin
                    n_phase = PH_DELTA; n_run = '0;  n_evst = '0;   n_tick = '0;
                    n_lval = '0;   n_lbytes = '0;    n_skip = '0;   n_meta = '0;
                    n_tempo = TEMPO_DEFAULT;         n_fdata = '0;  n_chseen = '0;
                    n_drum = 1'b0; n_notes = '0;     n_err = 1'b0;
                end
                default: n_kind = K_NONE;
            endcase
        end

        if (i_cmd.div_step) begin
            n_rem  = d_ge ? r_rem - d_sh[20:0] : r_rem;
            n_quo  = {r_quo[4:0], d_ge};
            n_dcnt = r_dcnt - 3'd1;
        end

        if (i_cmd.place) begin
            if (pl_out) begin
                n_kind = K_OUTSIDE;
            end else if (pl_drum) begin
                n_drum = 1'b1;
                n_kind = K_DRUM;
                n_row  = {3'b100, pl_trk};
                n_step = r_quo[4:0];
            end else begin
                o_stat.mel = 1'b1;
                n_chseen   = r_chseen | (16'd1 << r_ch);
                n_kind     = K_MELODIC;
                n_row      = {1'b0, r_ch};
                n_step     = r_quo[4:0];
            end
        end

        if (i_cmd.rd_take) begin
            if (rd_ok && !r_rrow[4]) n_cell = r_mel_rd;
            else if (rd_ok && r_rrow < 5'd20) n_cell = {7'd0, r_drm_rd};
            else n_cell = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= i_func;
            r_byte  <= i_byte;
            r_ts    <= i_ts;
            r_te    <= i_te;
            r_rrow  <= i_rrow;
            r_rstep <= i_rstep;
        end
        r_ch   <= n_ch;   r_rem  <= n_rem;  r_quo  <= n_quo;
        r_kind <= n_kind; r_row  <= n_row;  r_step <= n_step;
        r_note <= n_note; r_cell <= n_cell; r_meta <= n_meta;
        r_fdata <= n_fdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DELTA; r_run <= '0;  r_evst <= '0;   r_tick <= '0;
            r_lval <= '0;   r_lbytes <= '0;    r_skip <= '0;   r_tempo <= TEMPO_DEFAULT;
            r_chseen <= '0; r_drum <= 1'b0;    r_notes <= '0;  r_err <= 1'b0;
            r_dcnt <= '0;   r_clr_addr <= '0;  r_m_valid <= 1'b0;
        end else begin
            r_phase <= n_phase; r_run <= n_run;   r_evst <= n_evst; r_tick <= n_tick;
            r_lval <= n_lval;   r_lbytes <= n_lbytes; r_skip <= n_skip; r_tempo <= n_tempo;
            r_chseen <= n_chseen; r_drum <= n_drum; r_notes <= n_notes; r_err <= n_err;
            r_dcnt <= n_dcnt;
            if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + MAW'(1);
            if (i_cmd.push) r_m_valid <= 1'b1;
            else if (i_m_ready) r_m_valid <= 1'b0;
        end
    end

    // output register: snapshot of the result and the running statistics
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_m_data <= {3'd0, r_drum, r_chseen, r_notes, r_tempo, r_cell,
                         r_note, r_step, r_row, r_kind};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) mem_mel[r_clr_addr] <= 8'd0;
        else if (i_cmd.mel_wr && mel_upd) mem_mel[pl_addr] <= {1'b0, r_note} + 8'd1;
        r_mel_rd <= mem_mel[mel_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) mem_drm[r_clr_addr[DAW-1:0]] <= 1'b0;
        else if (i_cmd.place && !pl_out && pl_drum) mem_drm[drm_pl_addr] <= 1'b1;
        r_drm_rd <= mem_drm[drm_rd_addr];
    end

    assign o_m_valid = r_m_valid;
    assign o_m_data  = r_m_data;

endmodule

>>> rtl/midi_track_step_quantizer.sv
// ============================================================================
// midi_track_step_quantizer
// MIDI track byte parser that quantizes note-ons onto a step grid.
// ============================================================================
// Usage:
//   The slave stream carries one item per transfer: a track byte, a cell read
//   or a clear for a new file. Every item gives exactly one result transfer
//   on the master stream. The APB port holds ticks per quarter, bar count
//   and drum channel; write it only while the block is idle.
//   Steps: a plain track byte, and a note-on outside the window, go from
//   execute to output; a cell read adds a read-data step; a drum note-on
//   inside the window adds the restoring step divider and a place step,
//   and a melodic note-on inside the window also a grid write step.
//   Items are taken one at a time; the sequencer sets the rate.
//   Reset, and a clear item, start a sweep that zeroes both note grids, one
//   entry per cycle, over 16 * 2^ceil(log2(STEPS_MAX)) entries, 512 by default.
//   s_tready stays low during the sweep; configuration writes still land.
//   A finished result sits in the output register while the next item is
//   taken; when the receiver stalls and the register is full, the block
//   holds the next result until the register frees up.
// ============================================================================
module midi_track_step_quantizer
    import mtsq_pkg::*;
#(
    parameter int STEPS_MAX = STEPS_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte[7:0], read_row[12:8], read_step[17:13]
    input  logic        s_tlast,   // track_end
    input  logic [2:0]  s_tuser,   // func[1:0], track_start[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    // kind[2:0], row[7:3], step[12:8], note[19:13], cell_res[27:20],
    // tempo[51:28], note_count[67:52], melodic_mask[83:68], drum_seen[84]
    output logic [87:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [14:0] r_tpq;
    logic [1:0]  r_bars;
    logic [3:0]  r_drum_ch;
    logic        cfg_wr;
    t_cmd        cmd;
    t_stat       stat;
    logic        ready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // configuration registers, one word apart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpq     <= TPQ_RST;
            r_bars    <= BARS_RST;
            r_drum_ch <= DRUM_CH_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_TPQ:  r_tpq     <= pwdata[14:0];
                REG_BARS: r_bars    <= pwdata[1:0];
                REG_DRUM: r_drum_ch <= pwdata[3:0];
                default:  ;   // no register here, drop the write
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TPQ:  prdata = {17'd0, r_tpq};
            REG_BARS: prdata = {30'd0, r_bars};
            REG_DRUM: prdata = {28'd0, r_drum_ch};
            default:  prdata = '0;
        endcase
    end

    assign s_tready = ready;

    mtsq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_tvalid && ready),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_ready  (ready)
    );

    mtsq_dp #(
        .STEPS_MAX (STEPS_MAX)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_func    (s_tuser[1:0]),
        .i_byte    (s_tdata[7:0]),
        .i_ts      (s_tuser[2]),
        .i_te      (s_tlast),
        .i_rrow    (s_tdata[12:8]),
        .i_rstep   (s_tdata[17:13]),
        .i_tpq     (r_tpq),
        .i_bars    (r_bars),
        .i_drum_ch (r_drum_ch),
        .i_m_ready (m_tready),
        .o_m_valid (m_tvalid),
        .o_m_data  (m_tdata)
    );

endmodule

>>> rtl/mtsq_chk.sv
// ============================================================================
// mtsq_chk
// Port checker for the MIDI track step quantizer, bound to the top level.
// ============================================================================
module mtsq_chk
    import mtsq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata
);

    // hold a stalled result
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // grid sweep follows reset, no transfer taken
    a_sweep_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_tready)
        else $error("input taken before grid sweep");

    a_drum_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[2:0] == K_DRUM |-> m_tdata[84])
        else $error("drum hit without drum flag");

    a_mel_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[2:0] == K_MELODIC |-> m_tdata[83:68] != 16'd0)
        else $error("melodic note without channel mask");

endmodule

bind midi_track_step_quantizer mtsq_chk u_chk (.*);
